>>> hdl/m6502eu_pkg.sv
package m6502eu_pkg;

   localparam int unsigned ActionWidth = 6;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned AddrWidth   = 16;

   localparam logic [ActionWidth-1:0] ACT_ADC = 6'd0;
   localparam logic [ActionWidth-1:0] ACT_AND = 6'd1;
   localparam logic [ActionWidth-1:0] ACT_ASL = 6'd2;
   localparam logic [ActionWidth-1:0] ACT_BIT = 6'd3;
   localparam logic [ActionWidth-1:0] ACT_CMP = 6'd4;
   localparam logic [ActionWidth-1:0] ACT_CPX = 6'd5;
   localparam logic [ActionWidth-1:0] ACT_CPY = 6'd6;
   localparam logic [ActionWidth-1:0] ACT_BCC = 6'd7;
   localparam logic [ActionWidth-1:0] ACT_BCS = 6'd8;
   localparam logic [ActionWidth-1:0] ACT_BEQ = 6'd9;
   localparam logic [ActionWidth-1:0] ACT_BMI = 6'd10;
   localparam logic [ActionWidth-1:0] ACT_BNE = 6'd11;
   localparam logic [ActionWidth-1:0] ACT_BPL = 6'd12;
   localparam logic [ActionWidth-1:0] ACT_BVC = 6'd13;
   localparam logic [ActionWidth-1:0] ACT_BVS = 6'd14;
   localparam logic [ActionWidth-1:0] ACT_CLC = 6'd15;
   localparam logic [ActionWidth-1:0] ACT_CLD = 6'd16;
   localparam logic [ActionWidth-1:0] ACT_CLI = 6'd17;
   localparam logic [ActionWidth-1:0] ACT_CLV = 6'd18;
   localparam logic [ActionWidth-1:0] ACT_DEC = 6'd19;
   localparam logic [ActionWidth-1:0] ACT_DEX = 6'd20;
   localparam logic [ActionWidth-1:0] ACT_DEY = 6'd21;
   localparam logic [ActionWidth-1:0] ACT_EOR = 6'd22;
   localparam logic [ActionWidth-1:0] ACT_INC = 6'd23;
   localparam logic [ActionWidth-1:0] ACT_INX = 6'd24;
   localparam logic [ActionWidth-1:0] ACT_INY = 6'd25;
   localparam logic [ActionWidth-1:0] ACT_JMP = 6'd26;
   localparam logic [ActionWidth-1:0] ACT_LDA = 6'd27;
   localparam logic [ActionWidth-1:0] ACT_LDX = 6'd28;
   localparam logic [ActionWidth-1:0] ACT_LDY = 6'd29;
   localparam logic [ActionWidth-1:0] ACT_LSR = 6'd30;
   localparam logic [ActionWidth-1:0] ACT_NOP = 6'd31;
   localparam logic [ActionWidth-1:0] ACT_ORA = 6'd32;
   localparam logic [ActionWidth-1:0] ACT_PHA = 6'd33;
   localparam logic [ActionWidth-1:0] ACT_PHP = 6'd34;
   localparam logic [ActionWidth-1:0] ACT_PLA = 6'd35;
   localparam logic [ActionWidth-1:0] ACT_PLP = 6'd36;
   localparam logic [ActionWidth-1:0] ACT_ROL = 6'd37;
   localparam logic [ActionWidth-1:0] ACT_ROR = 6'd38;

   localparam logic [ByteWidth-1:0] PushMask = 8'h30;
   localparam logic [ByteWidth-1:0] PullMask = 8'hCF;

   localparam logic [1:0] EXTRA_NONE  = 2'd0;
   localparam logic [1:0] EXTRA_TAKEN = 2'd1;
   localparam logic [1:0] EXTRA_PAGE  = 2'd2;

   typedef struct packed {
      logic [ActionWidth-1:0] action;
      logic [ByteWidth-1:0]   operand;
      logic                   on_accumulator;
      logic [AddrWidth-1:0]   next_pc;
      logic [AddrWidth-1:0]   target;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] acc;
      logic [ByteWidth-1:0] reg_x;
      logic [ByteWidth-1:0] reg_y;
      logic [ByteWidth-1:0] flags;
      logic [AddrWidth-1:0] new_pc;
      logic                 write_enable;
      logic [ByteWidth-1:0] write_value;
      logic [1:0]           extra_cycles;
   } rsp_type;

endpackage

>>> hdl/m6502eu_chan_if.sv
interface m6502eu_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/mos6502_execute_unit_top.sv
// 6502 execute unit: takes one decoded instruction per item on req_channel and returns one
// item on rsp_channel with A, X, Y and P after the instruction, the next program counter,
// an optional memory or stack write byte and the extra cycles of a taken branch. Throughput
// is one instruction per clock while rsp_channel is not stalled. An accepted item is
// registered in the input register, then executed into the result register, from which
// it leaves on rsp_channel. While a result waits on rsp_channel one more item is
// held in the input register, then the input stalls until the result leaves.
// The architectural registers update as each item passes the execute logic, so every
// instruction sees the effect of the one before it. Arithmetic is binary only; D is kept but
// never used.
module mos6502_execute_unit_top (
   input logic clock,
   input logic reset,
   m6502eu_chan_if.sink   req_channel,
   m6502eu_chan_if.source rsp_channel
);
   import m6502eu_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   req_type hold_ff, hold_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic [ByteWidth-1:0] a_ff, a_in;
   logic [ByteWidth-1:0] x_ff, x_in;
   logic [ByteWidth-1:0] y_ff, y_in;
   logic [ByteWidth-1:0] p_ff, p_in;

   logic advance;
   logic take_req;

   function automatic logic [ByteWidth-1:0] set_zn(input logic [ByteWidth-1:0] p,
                                                   input logic [ByteWidth-1:0] v);
      return {v[7], p[6:2], (v == '0), p[0]};
   endfunction

   assign advance  = hold_valid_ff && (!out_valid_ff || rsp_channel.ready);
   assign take_req = req_channel.valid && req_channel.ready;

   assign req_channel.ready   = !hold_valid_ff || advance;
   assign rsp_channel.valid   = out_valid_ff;
   assign rsp_channel.payload = out_ff;

   always_comb begin
      logic [ByteWidth:0]   sum;
      logic [ByteWidth:0]   diff;
      logic [ByteWidth-1:0] cmp_src;
      logic [ByteWidth-1:0] sh_src;
      logic [ByteWidth-1:0] sh_res;
      logic                 sh_carry;
      logic                 taken;
      logic [AddrWidth-1:0] pc;
      logic                 we;
      logic [ByteWidth-1:0] wv;

      a_in = a_ff;
      x_in = x_ff;
      y_in = y_ff;
      p_in = p_ff;
      pc = hold_ff.next_pc;
      we = 1'b0;
      wv = '0;
      taken = 1'b0;
      sum = {1'b0, a_ff} + {1'b0, hold_ff.operand} + {{ByteWidth{1'b0}}, p_ff[0]};
      cmp_src = (hold_ff.action == ACT_CPX) ? x_ff :
                (hold_ff.action == ACT_CPY) ? y_ff : a_ff;
      diff = {1'b1, cmp_src} - {1'b0, hold_ff.operand};
      sh_src = hold_ff.on_accumulator ? a_ff : hold_ff.operand;
      sh_carry = sh_src[0];
      sh_res = {p_ff[0], sh_src[7:1]};
      unique case (hold_ff.action)
         ACT_ASL: begin
            sh_carry = sh_src[7];
            sh_res = {sh_src[6:0], 1'b0};
         end
         ACT_LSR: sh_res = {1'b0, sh_src[7:1]};
         ACT_ROL: begin
            sh_carry = sh_src[7];
            sh_res = {sh_src[6:0], p_ff[0]};
         end
         default: ;
      endcase

      unique case (hold_ff.action) inside
         ACT_ADC: begin
            a_in = sum[ByteWidth-1:0];
            p_in = set_zn(p_ff, sum[ByteWidth-1:0]);
            p_in[0] = sum[ByteWidth];
            p_in[6] = ~(a_ff[7] ^ hold_ff.operand[7]) & (a_ff[7] ^ sum[7]);
         end
         ACT_AND: begin
            a_in = a_ff & hold_ff.operand;
            p_in = set_zn(p_ff, a_ff & hold_ff.operand);
         end
         ACT_BIT: begin
            p_in = {hold_ff.operand[7:6], p_ff[5:2],
                    ((hold_ff.operand & a_ff) == '0), p_ff[0]};
         end
         ACT_CMP, ACT_CPX, ACT_CPY: begin
            p_in = set_zn(p_ff, diff[ByteWidth-1:0]);
            p_in[0] = diff[ByteWidth];
         end
         ACT_BCC: taken = !p_ff[0];
         ACT_BCS: taken = p_ff[0];
         ACT_BEQ: taken = p_ff[1];
         ACT_BMI: taken = p_ff[7];
         ACT_BNE: taken = !p_ff[1];
         ACT_BPL: taken = !p_ff[7];
         ACT_BVC: taken = !p_ff[6];
         ACT_BVS: taken = p_ff[6];
         ACT_CLC: p_in[0] = 1'b0;
         ACT_CLD: p_in[3] = 1'b0;
         ACT_CLI: p_in[2] = 1'b0;
         ACT_CLV: p_in[6] = 1'b0;
         ACT_DEC: begin
            we = 1'b1;
            wv = hold_ff.operand - 8'd1;
            p_in = set_zn(p_ff, hold_ff.operand - 8'd1);
         end
         ACT_DEX: begin
            x_in = x_ff - 8'd1;
            p_in = set_zn(p_ff, x_ff - 8'd1);
         end
         ACT_DEY: begin
            y_in = y_ff - 8'd1;
            p_in = set_zn(p_ff, y_ff - 8'd1);
         end
         ACT_EOR: begin
            a_in = a_ff ^ hold_ff.operand;
            p_in = set_zn(p_ff, a_ff ^ hold_ff.operand);
         end
         ACT_INC: begin
            we = 1'b1;
            wv = hold_ff.operand + 8'd1;
            p_in = set_zn(p_ff, hold_ff.operand + 8'd1);
         end
         ACT_INX: begin
            x_in = x_ff + 8'd1;
            p_in = set_zn(p_ff, x_ff + 8'd1);
         end
         ACT_INY: begin
            y_in = y_ff + 8'd1;
            p_in = set_zn(p_ff, y_ff + 8'd1);
         end
         ACT_JMP: pc = hold_ff.target;
         ACT_LDA, ACT_PLA: begin
            a_in = hold_ff.operand;
            p_in = set_zn(p_ff, hold_ff.operand);
         end
         ACT_LDX: begin
            x_in = hold_ff.operand;
            p_in = set_zn(p_ff, hold_ff.operand);
         end
         ACT_LDY: begin
            y_in = hold_ff.operand;
            p_in = set_zn(p_ff, hold_ff.operand);
         end
         ACT_ORA: begin
            a_in = a_ff | hold_ff.operand;
            p_in = set_zn(p_ff, a_ff | hold_ff.operand);
         end
         ACT_PHA: begin
            we = 1'b1;
            wv = a_ff;
         end
         ACT_PHP: begin
            we = 1'b1;
            wv = p_ff | PushMask;
         end
         ACT_PLP: p_in = hold_ff.operand & PullMask;
         ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR: begin
            p_in = set_zn(p_ff, sh_res);
            p_in[0] = sh_carry;
            if (hold_ff.on_accumulator) begin
               a_in = sh_res;
            end else begin
               we = 1'b1;
               wv = sh_res;
            end
         end
         default: ;
      endcase

      out_in.extra_cycles = EXTRA_NONE;
      if (taken) begin
         pc = hold_ff.target;
         out_in.extra_cycles = (hold_ff.next_pc[15:8] != hold_ff.target[15:8]) ?
                               EXTRA_PAGE : EXTRA_TAKEN;
      end
      out_in.acc = a_in;
      out_in.reg_x = x_in;
      out_in.reg_y = y_in;
      out_in.flags = p_in;
      out_in.new_pc = pc;
      out_in.write_enable = we;
      out_in.write_value = wv;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in = hold_ff;
      if (take_req) begin
         hold_valid_in = 1'b1;
         hold_in = req_channel.payload;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         a_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         p_ff <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            a_ff <= a_in;
            x_ff <= x_in;
            y_ff <= y_in;
            p_ff <= p_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> hdl/m6502eu_checker.sv
module m6502eu_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input m6502eu_pkg::rsp_type rsp_payload
);
   import m6502eu_pkg::*;

   // hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_enable |-> rsp_payload.write_value == '0)
      else $error("write value without write enable");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.flags[5:4] == 2'b00)
      else $error("unused status bits set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.extra_cycles != 2'd3)
      else $error("bad extra cycle count");

endmodule

bind mos6502_execute_unit_top m6502eu_checker u_m6502eu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_channel.valid),
   .rsp_ready   (rsp_channel.ready),
   .rsp_payload (rsp_channel.payload)
);
